// ===== hdl/oaht_pkg.sv =====
// Shared types and constants for the open addressing hash table.
package oaht_pkg;

   localparam int CNT_W = 11;

   localparam logic [1:0] CMD_GET    = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_NEXT   = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_TOO_LARGE = 2'd2;
   localparam logic [1:0] STAT_OVERLOAD  = 2'd3;

   localparam logic [1:0] FLAG_EMPTY   = 2'd0;
   localparam logic [1:0] FLAG_USED    = 2'd1;
   localparam logic [1:0] FLAG_REMOVED = 2'd2;

   localparam logic [1:0] CSR_SLOT_COUNT = 2'd0;
   localparam logic [1:0] CSR_FILL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_KEY_LIMIT  = 2'd2;
   localparam logic [1:0] CSR_VAL_LIMIT  = 2'd3;

   localparam logic [10:0] SLOT_COUNT_RST = 11'd53;
   localparam logic [10:0] FILL_LIMIT_RST = 11'd34;
   localparam logic [3:0]  KEY_LIMIT_RST  = 4'd8;
   localparam logic [3:0]  VAL_LIMIT_RST  = 4'd8;

   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam logic [10:0] COUNT_MAX = 11'd2047;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] key_bytes;
      logic [3:0]  key_len;
      logic [63:0] value_bytes;
      logic [3:0]  value_len;
      logic [10:0] start_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot;
      logic [63:0] out_key;
      logic [3:0]  out_key_len;
      logic [63:0] out_value;
      logic [3:0]  out_value_len;
      logic [10:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_FAIL, OP_HIT, OP_REMOVE, OP_UPDATE, OP_INSERT
   } res_op_type;

   typedef struct packed {
      logic       load;
      logic       hash_step;
      logic       div_init;
      logic       div_step;
      logic       probe_init;
      logic       scan_init;
      logic       rd;
      logic       advance;
      logic       scan_adv;
      logic       sweep_init;
      logic       sweep_step;
      res_op_type res_op;
      logic [1:0] res_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       too_large;
      logic       start_oob;
      logic       hash_done;
      logic       div_done;
      logic [1:0] flag;
      logic       match;
      logic       wrap;
      logic       scan_end;
      logic       clear_last;
      logic       wipe_last;
      logic       overload;
   } dp_stat_type;

endpackage

// ===== hdl/oaht_dp.sv =====
// Datapath: config registers, hash, modulo unit, probe arithmetic and slot stores.
module oaht_dp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  oaht_pkg::req_type      req_payload,
   input  logic                   csr_we,
   input  logic [1:0]             csr_idx,
   input  logic [10:0]            csr_wdata,
   input  oaht_pkg::ctrl_cmd_type ctl,
   output oaht_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   output oaht_pkg::rsp_type      rsp_payload
);
   import oaht_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int KW = KEY_BYTES * 8;
   localparam int VW = VALUE_BYTES * 8;
   localparam int DEPTH_CAP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;

   typedef struct packed {
      logic [KW-1:0] key;
      logic [3:0]    klen;
      logic [VW-1:0] val;
      logic [3:0]    vlen;
   } entry_type;

   // config
   logic [10:0] slot_count_ff, slot_count_in, fill_ff, fill_in;
   logic [3:0]  klim_ff, klim_in, vlim_ff, vlim_in;
   // request
   logic [1:0]    cmd_ff;
   logic [KW-1:0] key_ff;
   logic [3:0]    klen_ff;
   logic [VW-1:0] val_ff;
   logic [3:0]    vlen_ff;
   logic [10:0]   start_ff, n_ff;
   // hash / modulo
   logic [31:0]   hash_ff, hash_in;
   logic [KW-1:0] hkey_ff, hkey_in;
   logic [3:0]    hcnt_ff, hcnt_in;
   logic [5:0]    dcnt_ff, dcnt_in;
   logic [10:0]   home_ff, home_in;
   logic [11:0]   rem_sh;
   logic [7:0]    hbyte;
   // probe
   logic [10:0]   pos_ff, pos_in, step_ff, step_in, nxt, step_p1, step_nx, n_live;
   logic [11:0]   sum;
   logic [AW-1:0] clr_ff, clr_in, addr;
   logic [10:0]   count_ff, count_in;
   // stores
   logic [1:0]    flag_mem [TABLE_DEPTH];
   entry_type     entry_mem [TABLE_DEPTH];
   logic [1:0]    rd_flag_ff, flag_wd;
   entry_type     rd_entry_ff, ins_entry, upd_entry, entry_wd;
   logic          flag_we, entry_we;
   logic [AW-1:0] flag_wa;
   logic [KW-1:0] kmask;
   logic [VW-1:0] vmask;
   logic [3:0]    klim_eff, vlim_eff;
   logic          match_ok, match_live;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   always_comb begin
      slot_count_in = slot_count_ff;
      fill_in       = fill_ff;
      klim_in       = klim_ff;
      vlim_in       = vlim_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_SLOT_COUNT: slot_count_in = csr_wdata;
            CSR_FILL_LIMIT: fill_in = csr_wdata;
            CSR_KEY_LIMIT:  klim_in = csr_wdata[3:0];
            CSR_VAL_LIMIT:  vlim_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RST;
         fill_ff       <= FILL_LIMIT_RST;
         klim_ff       <= KEY_LIMIT_RST;
         vlim_ff       <= VAL_LIMIT_RST;
      end else begin
         slot_count_ff <= slot_count_in;
         fill_ff       <= fill_in;
         klim_ff       <= klim_in;
         vlim_ff       <= vlim_in;
      end
   end

   assign n_live = (slot_count_ff == 11'd0) ? 11'd1 :
                   (slot_count_ff > 11'(DEPTH_CAP)) ? 11'(DEPTH_CAP) : slot_count_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_payload.cmd;
         key_ff   <= req_payload.key_bytes[KW-1:0];
         klen_ff  <= req_payload.key_len;
         val_ff   <= req_payload.value_bytes[VW-1:0];
         vlen_ff  <= req_payload.value_len;
         start_ff <= req_payload.start_slot;
         n_ff     <= n_live;
      end
   end

   // djb2 one byte per cycle, then restoring remainder one bit per cycle
   assign hbyte  = hkey_ff[7:0];
   assign rem_sh = {home_ff, hash_ff[31]};

   always_comb begin
      hash_in = hash_ff;
      hkey_in = hkey_ff;
      hcnt_in = hcnt_ff;
      dcnt_in = dcnt_ff;
      home_in = home_ff;
      if (ctl.load) begin
         hash_in = HASH_SEED;
         hkey_in = req_payload.key_bytes[KW-1:0];
         hcnt_in = req_payload.key_len;
      end else if (ctl.hash_step) begin
         hash_in = (hash_ff << 5) + hash_ff + {{24{hbyte[7]}}, hbyte};
         hkey_in = hkey_ff >> 8;
         hcnt_in = hcnt_ff - 4'd1;
      end else if (ctl.div_init) begin
         home_in = 11'd0;
         dcnt_in = 6'd0;
      end else if (ctl.div_step) begin
         home_in = (rem_sh >= {1'b0, n_ff}) ? 11'(rem_sh - {1'b0, n_ff}) : rem_sh[10:0];
         hash_in = hash_ff << 1;
         dcnt_in = dcnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      hkey_ff <= hkey_in;
      hcnt_ff <= hcnt_in;
      dcnt_ff <= dcnt_in;
      home_ff <= home_in;
   end

   // probe position: triangular steps kept below n
   assign sum     = {1'b0, pos_ff} + {1'b0, step_ff};
   assign nxt     = (sum >= {1'b0, n_ff}) ? 11'(sum - {1'b0, n_ff}) : sum[10:0];
   assign step_p1 = step_ff + 11'd1;
   assign step_nx = (step_p1 == n_ff) ? 11'd0 : step_p1;

   always_comb begin
      pos_in  = pos_ff;
      step_in = step_ff;
      if (ctl.probe_init) begin
         pos_in  = home_ff;
         step_in = (n_ff == 11'd1) ? 11'd0 : 11'd1;
      end else if (ctl.scan_init) begin
         pos_in = start_ff;
      end else if (ctl.advance) begin
         pos_in  = nxt;
         step_in = step_nx;
      end else if (ctl.scan_adv) begin
         pos_in = pos_ff + 11'd1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      step_ff <= step_in;
   end

   always_comb begin
      clr_in = clr_ff;
      if (ctl.sweep_init)      clr_in = '0;
      else if (ctl.sweep_step) clr_in = clr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else       clr_ff <= clr_in;
   end

   // masks and entries to write
   always_comb begin
      for (int j = 0; j < KEY_BYTES; j++)
         kmask[j*8 +: 8] = (4'(j) < klen_ff) ? 8'hFF : 8'h00;
      for (int j = 0; j < VALUE_BYTES; j++)
         vmask[j*8 +: 8] = (4'(j) < vlen_ff) ? 8'hFF : 8'h00;
   end

   always_comb begin
      ins_entry.key  = key_ff & kmask;
      ins_entry.klen = klen_ff;
      ins_entry.val  = val_ff & vmask;
      ins_entry.vlen = vlen_ff;
      upd_entry      = rd_entry_ff;
      upd_entry.val  = val_ff & vmask;
      upd_entry.vlen = vlen_ff;
   end

   // key compare, stops at the first zero byte
   always_comb begin
      match_ok   = (rd_entry_ff.klen == klen_ff);
      match_live = 1'b1;
      for (int j = 0; j < KEY_BYTES; j++) begin
         if (match_live && (4'(j) < klen_ff)) begin
            if (key_ff[j*8 +: 8] != rd_entry_ff.key[j*8 +: 8]) match_ok = 1'b0;
            if (key_ff[j*8 +: 8] == 8'h00) match_live = 1'b0;
         end
      end
   end

   assign addr     = AW'(pos_ff);
   assign flag_we  = ctl.sweep_step || (ctl.res_op == OP_REMOVE) || (ctl.res_op == OP_INSERT);
   assign flag_wa  = ctl.sweep_step ? clr_ff : addr;
   assign flag_wd  = ctl.sweep_step ? FLAG_EMPTY :
                     (ctl.res_op == OP_REMOVE) ? FLAG_REMOVED : FLAG_USED;
   assign entry_we = (ctl.res_op == OP_UPDATE) || (ctl.res_op == OP_INSERT);
   assign entry_wd = (ctl.res_op == OP_INSERT) ? ins_entry : upd_entry;

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      if (ctl.rd)  rd_flag_ff <= flag_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (entry_we) entry_mem[addr] <= entry_wd;
      if (ctl.rd)   rd_entry_ff <= entry_mem[addr];
   end

   // result and entry count
   always_comb begin
      count_in = count_ff;
      if (ctl.res_op == OP_REMOVE && count_ff != 11'd0) count_in = count_ff - 11'd1;
      if (ctl.res_op == OP_INSERT && count_ff != COUNT_MAX) count_in = count_ff + 11'd1;
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = STAT_OK;
      rsp_in.slot          = pos_ff[9:0];
      rsp_in.entry_count   = count_in;
      case (ctl.res_op)
         OP_HIT, OP_REMOVE: begin
            rsp_in.out_key       = 64'(rd_entry_ff.key);
            rsp_in.out_key_len   = rd_entry_ff.klen;
            rsp_in.out_value     = 64'(rd_entry_ff.val);
            rsp_in.out_value_len = rd_entry_ff.vlen;
         end
         OP_UPDATE, OP_INSERT: begin
            rsp_in.out_key       = 64'(entry_wd.key);
            rsp_in.out_key_len   = entry_wd.klen;
            rsp_in.out_value     = 64'(entry_wd.val);
            rsp_in.out_value_len = entry_wd.vlen;
         end
         default: begin
            rsp_in.status = ctl.res_status;
            rsp_in.slot   = 10'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 11'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= (ctl.res_op != OP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.res_op != OP_NONE) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign klim_eff = (klim_ff > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : klim_ff;
   assign vlim_eff = (vlim_ff > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : vlim_ff;

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.too_large  = (klen_ff > klim_eff) || (vlen_ff > vlim_eff);
      stat.start_oob  = (start_ff >= n_ff);
      stat.hash_done  = (hcnt_ff == 4'd0);
      stat.div_done   = (dcnt_ff == 6'd32);
      stat.flag       = rd_flag_ff;
      stat.match      = match_ok;
      stat.wrap       = (nxt == home_ff);
      stat.scan_end   = (({1'b0, pos_ff} + 12'd1) >= {1'b0, n_ff});
      stat.clear_last = (clr_ff == AW'(TABLE_DEPTH - 1));
      stat.wipe_last  = (clr_ff == AW'(n_ff - 11'd1));
      stat.overload   = (count_ff > fill_ff);
   end

endmodule

// ===== hdl/oaht_ctrl.sv =====
// Controller state machine sequencing hash, modulo, probe chains and store sweeps.
module oaht_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  oaht_pkg::dp_stat_type  stat,
   output oaht_pkg::ctrl_cmd_type ctl
);
   import oaht_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_DISPATCH = 9'b000000100,
      S_HASH     = 9'b000001000,
      S_DIV      = 9'b000010000,
      S_RD       = 9'b000100000,
      S_EVAL     = 9'b001000000,
      S_WIPE     = 9'b010000000,
      S_WEND     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;
   logic      fin, fin_used, stop;

   assign stop = (stat.flag == FLAG_EMPTY) ||
                 ((stat.flag == FLAG_REMOVED) && pass2_ff) ||
                 ((stat.flag == FLAG_USED) && stat.match);

   always_comb begin
      state_in = state_ff;
      pass2_in = pass2_ff;
      ctl      = '0;
      fin      = 1'b0;
      fin_used = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctl.sweep_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            pass2_in = 1'b0;
            if (stat.cmd == CMD_NEXT) begin
               if (stat.start_oob) begin
                  ctl.res_op     = OP_FAIL;
                  ctl.res_status = STAT_NOT_FOUND;
                  state_in       = S_IDLE;
               end else begin
                  ctl.scan_init = 1'b1;
                  state_in      = S_RD;
               end
            end else if (stat.cmd == CMD_SET && stat.too_large) begin
               ctl.res_op     = OP_FAIL;
               ctl.res_status = STAT_TOO_LARGE;
               state_in       = S_IDLE;
            end else begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.hash_done) begin
               ctl.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               ctl.hash_step = 1'b1;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               ctl.probe_init = 1'b1;
               state_in       = S_RD;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         S_RD: begin
            ctl.rd   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.cmd == CMD_NEXT) begin
               if (stat.flag == FLAG_USED) begin
                  ctl.res_op = OP_HIT;
                  state_in   = S_IDLE;
               end else if (stat.scan_end) begin
                  ctl.res_op     = OP_FAIL;
                  ctl.res_status = STAT_NOT_FOUND;
                  state_in       = S_IDLE;
               end else begin
                  ctl.scan_adv = 1'b1;
                  state_in     = S_RD;
               end
            end else if (stop) begin
               fin      = 1'b1;
               fin_used = (stat.flag == FLAG_USED);
            end else if (stat.wrap) begin
               ctl.advance    = 1'b1;
               ctl.sweep_init = 1'b1;
               state_in       = S_WIPE;
            end else begin
               ctl.advance = 1'b1;
               state_in    = S_RD;
            end
         end
         S_WIPE: begin
            ctl.sweep_step = 1'b1;
            if (stat.wipe_last) state_in = S_WEND;
         end
         S_WEND: begin
            fin = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      // end of a probe chain at the current slot
      if (fin) begin
         state_in = S_IDLE;
         if (stat.cmd == CMD_SET) begin
            if (!pass2_ff && fin_used) begin
               ctl.res_op = OP_UPDATE;
            end else if (!pass2_ff) begin
               pass2_in       = 1'b1;
               ctl.probe_init = 1'b1;
               state_in       = S_RD;
            end else if (stat.overload) begin
               ctl.res_op     = OP_FAIL;
               ctl.res_status = STAT_OVERLOAD;
            end else begin
               ctl.res_op = OP_INSERT;
            end
         end else if (fin_used) begin
            ctl.res_op = (stat.cmd == CMD_REMOVE) ? OP_REMOVE : OP_HIT;
         end else begin
            ctl.res_op     = OP_FAIL;
            ctl.res_status = STAT_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hdl/open_addressing_hash_table.sv =====
// Top level of the open addressing key/value table with quadratic probing.
//
//  channel   ports                               transfer when
//  request   start, busy, req_payload            start high and busy low
//  response  rsp_valid, rsp_payload              rsp_valid high (one cycle)
//  config    csr_we, csr_idx, csr_wdata          csr_we high
//
// Per command: a dispatch state, then hashing, one step per key byte, and the
// modulo unit (one remainder bit a cycle), then a read and a compare state per
// probed slot (registered flag/entry read, then compare). A set that misses runs
// a second probe chain. A chain that wraps to its home slot sweeps slot_count
// flags, one a cycle, then closes the chain. Find-next scans slot by slot from
// start_slot. The response follows in the cycle after the last compare.
// After reset all TABLE_DEPTH flags are swept to empty, with busy high.
// Each response shows for one cycle; a new request may be taken in that cycle.
module open_addressing_hash_table #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oaht_pkg::req_type req_payload,
   output logic              rsp_valid,
   output oaht_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [1:0]        csr_idx,
   input  logic [10:0]       csr_wdata
);
   import oaht_pkg::*;

   ctrl_cmd_type ctl;
   dp_stat_type  stat;

   // sequencer: one command at a time
   oaht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   // hash, modulo, probe arithmetic and the slot stores
   oaht_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BYTES   (KEY_BYTES),
      .VALUE_BYTES (VALUE_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_idx     (csr_idx),
      .csr_wdata   (csr_wdata),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   // an accepted command always raises busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // every response is issued on the way back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // one response per command, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held two cycles");
`endif

endmodule
